>>> src/tbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

  // Table geometry.
  localparam int BIMODAL_BITS = 12;
  localparam int GSHARE_BITS  = 12;
  localparam int CHOOSER_BITS = 12;

  localparam int CLR_BITS =
    (BIMODAL_BITS >= GSHARE_BITS && BIMODAL_BITS >= CHOOSER_BITS) ? BIMODAL_BITS :
    (GSHARE_BITS >= CHOOSER_BITS) ? GSHARE_BITS : CHOOSER_BITS;

  // Global history and its length register.
  localparam int            HIST_W   = 20;
  localparam int            HL_W     = 5;
  localparam logic [HL_W-1:0] HL_RESET = 5'd12;

  // Stream and register port widths.
  localparam int ADDR_W     = 32;
  localparam int IN_W       = 40;
  localparam int OUT_FIELDS = 5;
  localparam int OUT_W      = 8;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  // Register index, taken from paddr bit 2.
  localparam logic REG_HIST_LEN = 1'b0;

  // 2-bit saturating counters.
  localparam int CTR_W = 2;
  typedef logic [CTR_W-1:0] ctr_t;
  localparam ctr_t CTR_MIN = 2'd0;
  localparam ctr_t CTR_MAX = 2'd3;

  function automatic ctr_t ctr_up(input ctr_t c);
    ctr_t r;
    r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    return r;
  endfunction

  function automatic ctr_t ctr_down(input ctr_t c);
    ctr_t r;
    r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    return r;
  endfunction

  function automatic ctr_t ctr_train(input ctr_t c, input logic t);
    ctr_t r;
    r = t ? ctr_up(c) : ctr_down(c);
    return r;
  endfunction

  // The chooser only moves when exactly one component was right.
  function automatic ctr_t chooser_train(input ctr_t c, input logic b_ok, input logic g_ok);
    ctr_t r;
    if (b_ok && !g_ok) begin
      r = ctr_down(c);
    end else if (g_ok && !b_ok) begin
      r = ctr_up(c);
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/tbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/tournament_branch_predictor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A result passes through stage 1 into the output register. Throughput: one branch per cycle
// while the output is not stalled; each table is one RAM with one read and one write port.
// A stalled result holds one more item in stage 1, and the input then waits for the output.
// Reset (synchronous, rst_n low) clears history and sets history_length to 12, then a clearing
// pass over 2^CLR_BITS (4096) entries zeroes all counter tables; in_tready is low until it ends.
module tournament_branch_predictor_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [31:0] branch_address, [32] taken, [39:33] zero
  input  wire logic [tbp_pkg::IN_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [0] bimodal_taken, [1] gshare_taken, [2] final_taken, [3] chose_gshare,
  // [4] mispredict, [7:5] zero
  output logic      [tbp_pkg::OUT_W-1:0]     out_tdata,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [tbp_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [tbp_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic      [tbp_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  import tbp_pkg::*;

  // Control state.
  logic                clearing_r, clearing_nxt;
  logic [CLR_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [HIST_W-1:0]   hist_r, hist_nxt;
  logic [HL_W-1:0]     hist_len_r, hist_len_nxt;
  logic                s1_valid_r, s1_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                fwd_b_r, fwd_b_nxt;
  logic                fwd_g_r, fwd_g_nxt;
  logic                fwd_c_r, fwd_c_nxt;

  // Stage 1 payload.
  logic [BIMODAL_BITS-1:0] s1_bi_r;
  logic [GSHARE_BITS-1:0]  s1_gi_r;
  logic [CHOOSER_BITS-1:0] s1_ci_r;
  logic                    s1_taken_r;
  ctr_t                    fwd_b_data_r, fwd_g_data_r, fwd_c_data_r;
  logic [OUT_FIELDS-1:0]   out_r;

  logic                    in_accept, s1_fire, cfg_write;
  logic [ADDR_W-1:0]       in_addr;
  logic                    in_taken;
  logic [GSHARE_BITS-1:0]  hmask;
  logic [BIMODAL_BITS-1:0] bi_in;
  logic [GSHARE_BITS-1:0]  gi_in;
  logic [CHOOSER_BITS-1:0] ci_in;

  ctr_t b_rdata, g_rdata, c_rdata;
  ctr_t b_cnt, g_cnt, c_cnt;
  ctr_t b_new, g_new, c_new;
  logic bp, gp, cp, fp;

  logic                    ram_we;
  logic [BIMODAL_BITS-1:0] b_waddr;
  logic [GSHARE_BITS-1:0]  g_waddr;
  logic [CHOOSER_BITS-1:0] c_waddr;
  ctr_t                    b_wdata, g_wdata, c_wdata;

  assign in_addr  = in_tdata[ADDR_W-1:0];
  assign in_taken = in_tdata[ADDR_W];

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clearing_r && (!s1_valid_r || s1_fire);
  assign in_accept = in_tvalid && in_tready;

  // Only the low history_length history bits take part; larger values saturate naturally.
  always_comb begin
    for (int i = 0; i < GSHARE_BITS; i++) begin
      hmask[i] = (HL_W'(i) < hist_len_r);
    end
  end

  assign bi_in = in_addr[BIMODAL_BITS-1:0];
  assign ci_in = in_addr[CHOOSER_BITS-1:0];
  assign gi_in = in_addr[GSHARE_BITS-1:0] ^ (hist_r[GSHARE_BITS-1:0] & hmask);

  // The RAM read misses the write made at the same edge, so that value is forwarded.
  assign b_cnt = fwd_b_r ? fwd_b_data_r : b_rdata;
  assign g_cnt = fwd_g_r ? fwd_g_data_r : g_rdata;
  assign c_cnt = fwd_c_r ? fwd_c_data_r : c_rdata;

  assign bp = b_cnt[CTR_W-1];
  assign gp = g_cnt[CTR_W-1];
  assign cp = c_cnt[CTR_W-1];
  assign fp = cp ? gp : bp;

  assign b_new = ctr_train(b_cnt, s1_taken_r);
  assign g_new = ctr_train(g_cnt, s1_taken_r);
  assign c_new = chooser_train(c_cnt, bp == s1_taken_r, gp == s1_taken_r);

  always_comb begin
    if (clearing_r) begin
      ram_we  = 1'b1;
      b_waddr = clr_cnt_r[BIMODAL_BITS-1:0];
      g_waddr = clr_cnt_r[GSHARE_BITS-1:0];
      c_waddr = clr_cnt_r[CHOOSER_BITS-1:0];
      b_wdata = CTR_MIN;
      g_wdata = CTR_MIN;
      c_wdata = CTR_MIN;
    end else begin
      ram_we  = s1_fire;
      b_waddr = s1_bi_r;
      g_waddr = s1_gi_r;
      c_waddr = s1_ci_r;
      b_wdata = b_new;
      g_wdata = g_new;
      c_wdata = c_new;
    end
  end

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(2 ** BIMODAL_BITS)) u_bimodal_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (in_accept),
    .raddr (bi_in),
    .rdata (b_rdata)
  );

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(2 ** GSHARE_BITS)) u_gshare_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (in_accept),
    .raddr (gi_in),
    .rdata (g_rdata)
  );

  tbp_ram #(.WIDTH(CTR_W), .DEPTH(2 ** CHOOSER_BITS)) u_chooser_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (in_accept),
    .raddr (ci_in),
    .rdata (c_rdata)
  );

  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == {CLR_BITS{1'b1}}) begin
        clearing_nxt = 1'b0;
      end
    end

    hist_len_nxt = hist_len_r;
    if (cfg_write && cfg_paddr[2] == REG_HIST_LEN) begin
      hist_len_nxt = cfg_pwdata[HL_W-1:0];
    end

    hist_nxt = hist_r;
    if (in_accept) begin
      hist_nxt = {hist_r[HIST_W-2:0], in_taken};
    end

    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // An accepted item overlaps only the item in stage 1, which writes at this edge.
    fwd_b_nxt = fwd_b_r;
    fwd_g_nxt = fwd_g_r;
    fwd_c_nxt = fwd_c_r;
    if (in_accept) begin
      fwd_b_nxt = s1_valid_r && (bi_in == s1_bi_r);
      fwd_g_nxt = s1_valid_r && (gi_in == s1_gi_r);
      fwd_c_nxt = s1_valid_r && (ci_in == s1_ci_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      hist_r      <= '0;
      hist_len_r  <= HL_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_b_r     <= 1'b0;
      fwd_g_r     <= 1'b0;
      fwd_c_r     <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hist_r      <= hist_nxt;
      hist_len_r  <= hist_len_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_b_r     <= fwd_b_nxt;
      fwd_g_r     <= fwd_g_nxt;
      fwd_c_r     <= fwd_c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_bi_r      <= bi_in;
      s1_gi_r      <= gi_in;
      s1_ci_r      <= ci_in;
      s1_taken_r   <= in_taken;
      fwd_b_data_r <= b_new;
      fwd_g_data_r <= g_new;
      fwd_c_data_r <= c_new;
    end
    if (s1_fire) begin
      out_r <= {fp != s1_taken_r, cp, fp, gp, bp};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-OUT_FIELDS){1'b0}}, out_r};

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_HIST_LEN) ?
                      {{(CFG_DW-HL_W){1'b0}}, hist_len_r} : '0;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_tready)
    else $error("input transfer accepted during table clearing");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted transfer did not reach stage 1");

  a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (fwd_b_r || fwd_g_r || fwd_c_r) && s1_valid_r |-> !clearing_r)
    else $error("forwarding active while tables are being cleared");

  a_final_matches_choice: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2] == (out_tdata[3] ? out_tdata[1] : out_tdata[0])))
    else $error("final prediction does not follow the chosen component");

endmodule

`default_nettype wire

>>> test/tournament_branch_predictor_checker.sv
`timescale 1ns / 1ps

module tournament_branch_predictor_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // [31:0] branch_address, [32] taken, [39:33] zero
  input  logic [tbp_pkg::IN_W-1:0]       in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] bimodal_taken, [1] gshare_taken, [2] final_taken, [3] chose_gshare,
  // [4] mispredict, [7:5] zero
  input  logic [tbp_pkg::OUT_W-1:0]      out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [tbp_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [tbp_pkg::CFG_DW-1:0]     cfg_pwdata,
  input  logic [tbp_pkg::CFG_DW-1:0]     cfg_prdata,
  input  logic                           cfg_pready,
  output int                             mismatches,
  output int                             outstanding
);

  localparam int BI_BITS  = tbp_pkg::BIMODAL_BITS;
  localparam int GS_BITS  = tbp_pkg::GSHARE_BITS;
  localparam int CH_BITS  = tbp_pkg::CHOOSER_BITS;
  localparam int HIST_W   = tbp_pkg::HIST_W;
  localparam int HL_W     = tbp_pkg::HL_W;
  localparam int ADDR_W   = tbp_pkg::ADDR_W;
  localparam int MAX_SHOWN = 10;

  localparam logic [1:0] CTR_FLOOR  = 2'd0;
  localparam logic [1:0] CTR_CEIL   = 2'd3;
  localparam logic [1:0] CTR_LEANS  = 2'd2;

  // Packed so that bimodal_taken lands in bit 0, as on out_tdata.
  typedef struct packed {
    logic mispredict;
    logic chose_gshare;
    logic final_taken;
    logic gshare_taken;
    logic bimodal_taken;
  } prediction_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic              outcome;
    prediction_t       pred;
  } branch_record_t;

  logic [1:0]        bim_ctr [0:(1<<BI_BITS)-1];
  logic [1:0]        gsh_ctr [0:(1<<GS_BITS)-1];
  logic [1:0]        cho_ctr [0:(1<<CH_BITS)-1];
  logic [HIST_W-1:0] path_hist;
  logic [HL_W-1:0]   hist_len;
  branch_record_t    predicted_q[$];

  function automatic logic [1:0] nudge(input logic [1:0] c, input logic up);
    if (up) begin
      return (c == CTR_CEIL) ? c : c + 2'd1;
    end
    return (c == CTR_FLOOR) ? c : c - 2'd1;
  endfunction

  // Forms the predictions from the counters as they stand, then trains
  // the tables and shifts the outcome into the path history.
  function automatic prediction_t predict_and_train(input logic [ADDR_W-1:0] addr,
                                                    input logic outcome);
    int                 eff_len;
    logic [31:0]        hmask;
    logic [BI_BITS-1:0] bi;
    logic [GS_BITS-1:0] gi;
    logic [CH_BITS-1:0] ci;
    logic               b_ok;
    logic               g_ok;
    prediction_t        p;
    eff_len = (hist_len > GS_BITS) ? GS_BITS : int'(hist_len);
    hmask   = (32'd1 << eff_len) - 32'd1;
    bi = addr[BI_BITS-1:0];
    ci = addr[CH_BITS-1:0];
    gi = addr[GS_BITS-1:0] ^ (path_hist[GS_BITS-1:0] & hmask[GS_BITS-1:0]);
    p.bimodal_taken = bim_ctr[bi] >= CTR_LEANS;
    p.gshare_taken  = gsh_ctr[gi] >= CTR_LEANS;
    p.chose_gshare  = cho_ctr[ci] >= CTR_LEANS;
    p.final_taken   = p.chose_gshare ? p.gshare_taken : p.bimodal_taken;
    p.mispredict    = p.final_taken != outcome;
    b_ok = p.bimodal_taken == outcome;
    g_ok = p.gshare_taken == outcome;
    if (b_ok != g_ok) begin
      cho_ctr[ci] = nudge(cho_ctr[ci], g_ok);
    end
    bim_ctr[bi] = nudge(bim_ctr[bi], outcome);
    gsh_ctr[gi] = nudge(gsh_ctr[gi], outcome);
    path_hist = {path_hist[HIST_W-2:0], outcome};
    return p;
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    branch_record_t rec;
    prediction_t    got;
    if (!rst_n) begin
      for (int i = 0; i < (1 << BI_BITS); i++) bim_ctr[i] = CTR_FLOOR;
      for (int i = 0; i < (1 << GS_BITS); i++) gsh_ctr[i] = CTR_FLOOR;
      for (int i = 0; i < (1 << CH_BITS); i++) cho_ctr[i] = CTR_FLOOR;
      path_hist = '0;
      hist_len  = tbp_pkg::HL_RESET;
      predicted_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[2] == tbp_pkg::REG_HIST_LEN) begin
        if (cfg_pwrite) begin
          hist_len = cfg_pwdata[HL_W-1:0];
        end else if (cfg_prdata !== {{(tbp_pkg::CFG_DW-HL_W){1'b0}}, hist_len}) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("history_length read: expected %0d, got 0x%08h", hist_len, cfg_prdata);
          end
        end
      end
      // Results pass through stage 1 and the output register before they leave, so the
      // output side is handled before this edge's input transfer is queued.
      if (out_tvalid && out_tready) begin
        got = prediction_t'(out_tdata[4:0]);
        if (predicted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("unexpected result transfer 0x%02h at %0t", out_tdata, $realtime);
          end
        end else begin
          rec = predicted_q.pop_front();
          if (got !== rec.pred) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
              $display("addr 0x%08h taken %0b: expected bim %0b gsh %0b fin %0b cho %0b mis %0b,",
                       rec.addr, rec.outcome, rec.pred.bimodal_taken, rec.pred.gshare_taken,
                       rec.pred.final_taken, rec.pred.chose_gshare, rec.pred.mispredict);
              $display("  got bim %0b gsh %0b fin %0b cho %0b mis %0b",
                       got.bimodal_taken, got.gshare_taken, got.final_taken,
                       got.chose_gshare, got.mispredict);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        rec.addr    = in_tdata[ADDR_W-1:0];
        rec.outcome = in_tdata[ADDR_W];
        rec.pred    = predict_and_train(rec.addr, rec.outcome);
        predicted_q.push_back(rec);
      end
    end
    outstanding = predicted_q.size();
  end

endmodule

>>> test/tournament_branch_predictor_core_test.sv
`timescale 1ns / 1ps

module tournament_branch_predictor_core_test;
  import tbp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int N_SITES        = 24;
  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 1700 / N_PHASES;

  localparam logic [CFG_AW-1:0] ADDR_HIST_LEN = {REG_HIST_LEN, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_SPARE    = {~REG_HIST_LEN, 2'b00};

  typedef enum int {
    KIND_ALWAYS,
    KIND_NEVER,
    KIND_ALTERNATE,
    KIND_LOOP,
    KIND_FOLLOW,
    KIND_BIASED
  } site_kind_e;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                mismatches;
  int                outstanding;

  // Branch sites that the random part draws from, each with its own habit.
  logic [ADDR_W-1:0] site_addr   [N_SITES];
  site_kind_e        site_kind   [N_SITES];
  int                site_period [N_SITES];
  int                site_iter   [N_SITES];
  logic              last_outcome;
  bit                sender_calm;
  int                idle_cycles;

  tournament_branch_predictor_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  tournament_branch_predictor_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Mostly back to back, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic outcome);
    int gap;
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= IN_W'({$urandom(), $urandom()});
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-ADDR_W-1){1'b0}}, outcome, addr};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic apb_access(input logic write, input logic [CFG_AW-1:0] addr,
                            input logic [HL_W-1:0] value);
    logic [CFG_DW-1:0] word;
    word = $urandom();
    word[HL_W-1:0] = value;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= word;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Drops the input valid and waits until every queued result is out.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void pick_branch(output logic [ADDR_W-1:0] addr, output logic outcome);
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      addr    = $urandom();
      outcome = 1'($urandom_range(0, 1));
    end else begin
      s = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 7) : $urandom_range(0, N_SITES - 1);
      addr = site_addr[s];
      case (site_kind[s])
        KIND_ALWAYS:    outcome = 1'b1;
        KIND_NEVER:     outcome = 1'b0;
        KIND_ALTERNATE: outcome = site_iter[s][0];
        KIND_LOOP:      outcome = (site_iter[s] % site_period[s]) != site_period[s] - 1;
        KIND_FOLLOW:    outcome = last_outcome;
        default:        outcome = $urandom_range(0, 3) != 0;
      endcase
      site_iter[s]++;
      // Occasional flips keep the counters from settling for good.
      if (r >= 95) outcome = !outcome;
    end
    last_outcome = outcome;
  endfunction

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stalls, calm stretches, and long hold-offs that
  // back the block up into its input.
  initial begin
    int  stall;
    int  results_seen;
    int  next_hold_at;
    bit  calm;
    out_tready   = 1'b0;
    stall        = 0;
    results_seen = 0;
    next_hold_at = 300;
    calm         = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) results_seen++;
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) calm = !calm;
      if (results_seen >= next_hold_at) begin
        stall        = HOLD_CYCLES;
        next_hold_at = next_hold_at + 700;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (!calm) stall = pick_gap();
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] addr;
    logic              outcome;
    logic [HL_W-1:0]   phase_len [N_PHASES];
    sender_calm  = 1'b0;
    last_outcome = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset history length, address extremes, then saturation both ways.
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    repeat (6) send_branch(32'h0000_0040, 1'b1);
    repeat (5) send_branch(32'h0000_0040, 1'b0);
    send_branch(32'hAAAA_AAAA, 1'b1);
    send_branch(32'h5555_5555, 1'b0);
    apb_access(1'b0, ADDR_HIST_LEN, '0);
    settle();

    // No history: gshare indexed by address alone.
    apb_access(1'b1, ADDR_HIST_LEN, 5'd0);
    send_branch(32'h0000_0040, 1'b1);
    send_branch(32'hFFFF_F040, 1'b0);
    send_branch(32'h1234_5678, 1'b1);
    settle();

    // Lengths beyond the gshare index width saturate.
    apb_access(1'b1, ADDR_HIST_LEN, 5'd31);
    send_branch(32'h0000_0040, 1'b0);
    send_branch(32'h0000_0FFF, 1'b1);
    send_branch(32'hFFFF_F000, 1'b1);
    settle();

    // A write to the unmapped register must leave history_length alone.
    apb_access(1'b1, ADDR_SPARE, 5'd3);
    apb_access(1'b0, ADDR_HIST_LEN, '0);
    apb_access(1'b1, ADDR_HIST_LEN, 5'd20);
    send_branch(32'h0000_0040, 1'b1);
    send_branch(32'h8000_0001, 1'b0);
    send_branch(32'h7FFF_FFFE, 1'b1);
    settle();

    phase_len[0] = 5'd0;
    phase_len[1] = 5'd12;
    phase_len[2] = 5'd31;
    phase_len[3] = 5'd1;
    phase_len[4] = 5'd20;
    phase_len[5] = HL_W'($urandom_range(0, 31));
    phase_len[6] = 5'd13;
    phase_len[7] = HL_W'($urandom_range(2, 11));

    for (int p = 0; p < N_PHASES; p++) begin
      apb_access(1'b1, ADDR_HIST_LEN, phase_len[p]);
      if (p % 2 == 1) apb_access(1'b0, ADDR_HIST_LEN, '0);
      if (p == 3) apb_access(1'b1, ADDR_SPARE, HL_W'($urandom_range(0, 31)));
      for (int s = 0; s < N_SITES; s++) begin
        site_addr[s] = $urandom();
        // Some sites share low bits with their neighbor, so only the tag differs.
        if (s > 0 && $urandom_range(0, 7) == 0) begin
          site_addr[s] = (site_addr[s-1] & 32'h0000_0FFF) | (site_addr[s] & 32'hFFFF_F000);
        end
        site_kind[s]   = site_kind_e'($urandom_range(0, 5));
        site_period[s] = $urandom_range(2, 8);
        site_iter[s]   = 0;
      end
      repeat (PHASE_ITEMS) begin
        pick_branch(addr, outcome);
        send_branch(addr, outcome);
      end
      settle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
